// ===== design/stl_pkg.sv =====
// Package for the source text lexer: scan modes, token codes, character
// constants, the keyword table and the token lookup functions. No dependencies.
`timescale 1ns / 1ps

package stl_pkg;

  localparam int unsigned POS_BITS_DEF  = 24;
  localparam int unsigned LINE_BITS_DEF = 16;
  localparam int unsigned KW_BITS       = 40;
  localparam int unsigned KW_COUNT      = 8;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_STR  = 3'd3,
    MODE_EQ   = 3'd4,
    MODE_BANG = 3'd5,
    MODE_LT   = 3'd6,
    MODE_GT   = 3'd7
  } scan_mode_e;

  typedef enum logic [4:0] {
    TOK_EOF       = 5'd0,
    TOK_IF        = 5'd1,
    TOK_ELSE      = 5'd2,
    TOK_WHILE     = 5'd3,
    TOK_INT       = 5'd4,
    TOK_BOOL      = 5'd5,
    TOK_TRUE      = 5'd6,
    TOK_FALSE     = 5'd7,
    TOK_PRINT     = 5'd8,
    TOK_IDENT     = 5'd9,
    TOK_NUMBER    = 5'd10,
    TOK_STRING    = 5'd11,
    TOK_LPAREN    = 5'd12,
    TOK_RPAREN    = 5'd13,
    TOK_LBRACE    = 5'd14,
    TOK_RBRACE    = 5'd15,
    TOK_SEMI      = 5'd16,
    TOK_PLUS      = 5'd17,
    TOK_MINUS     = 5'd18,
    TOK_STAR      = 5'd19,
    TOK_SLASH     = 5'd20,
    TOK_ASSIGN    = 5'd21,
    TOK_EQEQ      = 5'd22,
    TOK_NEQ       = 5'd23,
    TOK_LESS      = 5'd24,
    TOK_LESSEQ    = 5'd25,
    TOK_GREATER   = 5'd26,
    TOK_GREATEREQ = 5'd27,
    TOK_ERROR     = 5'd28,
    TOK_UNTERM    = 5'd29
  } token_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Keyword spellings, packed with the last letter in the low byte.
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    40'h0000006966, 40'h00656C7365, 40'h7768696C65, 40'h0000696E74,
    40'h00626F6F6C, 40'h0074727565, 40'h66616C7365, 40'h7072696E74
  };

  localparam token_e KW_TOKEN [KW_COUNT] = '{
    TOK_IF, TOK_ELSE, TOK_WHILE, TOK_INT, TOK_BOOL, TOK_TRUE, TOK_FALSE, TOK_PRINT
  };

  function automatic token_e word_code(input logic [KW_BITS-1:0] buf_v,
                                       input logic too_long);
    token_e code;
    code = TOK_IDENT;
    if (!too_long) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (buf_v == KW_TEXT[k]) begin
          code = KW_TOKEN[k];
        end
      end
    end
    return code;
  endfunction

  // Tokens made of one byte that needs no lookahead; anything unlisted is an error.
  function automatic token_e single_code(input logic [7:0] c);
    token_e code;
    unique case (c)
      CH_LPAREN: code = TOK_LPAREN;
      CH_RPAREN: code = TOK_RPAREN;
      CH_LBRACE: code = TOK_LBRACE;
      CH_RBRACE: code = TOK_RBRACE;
      CH_SEMI:   code = TOK_SEMI;
      CH_PLUS:   code = TOK_PLUS;
      CH_MINUS:  code = TOK_MINUS;
      CH_STAR:   code = TOK_STAR;
      CH_SLASH:  code = TOK_SLASH;
      default:   code = TOK_ERROR;
    endcase
    return code;
  endfunction

endpackage

// ===== design/source_text_lexer.sv =====
// Source text lexer top level: byte scanner and a four-entry result queue.
// Depends on stl_pkg.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | ch_i, end_of_input_i
//  out     | output    | out_valid_o/out_ready_i | token_type_o, start_pos_o,
//          |           |                         | length_o, line_no_o, last_o
//
// One byte is scanned per cycle while in_ready_o is high; its up to two tokens
// are written into the result queue at the same edge, so they are in the queue
// from the next cycle on. A new request is taken whenever the queue has room for
// two tokens; the queue depth sets the stall behaviour.
// Reset clears the scan state (line count to one) and empties the queue.
// An end mark returns the scan state to its reset values after its tokens.
`timescale 1ns / 1ps

module source_text_lexer #(
  parameter int unsigned POS_BITS  = stl_pkg::POS_BITS_DEF,
  parameter int unsigned LINE_BITS = stl_pkg::LINE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           ch_i,
  input  logic                 end_of_input_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [4:0]           token_type_o,
  output logic [POS_BITS-1:0]  start_pos_o,
  output logic [POS_BITS-1:0]  length_o,
  output logic [LINE_BITS-1:0] line_no_o,
  output logic                 last_o
);

  localparam int unsigned DEPTH  = 4;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned KW_W   = stl_pkg::KW_BITS;

  typedef struct packed {
    logic [4:0]           kind;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  len;
    logic [LINE_BITS-1:0] line;
    logic                 last;
  } result_t;

  stl_pkg::scan_mode_e  mode_q, mode_d;
  logic [POS_BITS-1:0]  tok_start_q, tok_start_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [KW_W-1:0]      kw_buf_q, kw_buf_d;
  logic                 too_long_q, too_long_d;

  result_t              mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q;

  logic in_fire, out_fire;
  logic [POS_BITS-1:0]  pos_inc;
  logic [LINE_BITS-1:0] line_inc;
  logic is_alpha, is_digit, is_word;
  logic is_quote, is_op2, is_space, is_nl, is_wstart;
  logic pending, is_op_mode, cont, flush_en, start_en, single_en;
  logic a_en, b_en;
  result_t res_a, res_b;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o = (cnt_q <= CNT_W'(DEPTH - 2));

  assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + POS_BITS'(1);
  assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);

  assign is_alpha  = (ch_i >= 8'h61 && ch_i <= 8'h7A) || (ch_i >= 8'h41 && ch_i <= 8'h5A);
  assign is_digit  = (ch_i >= 8'h30 && ch_i <= 8'h39);
  assign is_word   = is_alpha || is_digit || (ch_i == stl_pkg::CH_UNDER);
  assign is_wstart = is_alpha || (ch_i == stl_pkg::CH_UNDER);
  assign is_quote  = (ch_i == stl_pkg::CH_QUOTE);
  assign is_op2    = (ch_i == stl_pkg::CH_EQUALS) || (ch_i == stl_pkg::CH_BANG) ||
                     (ch_i == stl_pkg::CH_LESS) || (ch_i == stl_pkg::CH_GREATER);
  assign is_space  = (ch_i == stl_pkg::CH_SPACE) || (ch_i == stl_pkg::CH_TAB) ||
                     (ch_i == stl_pkg::CH_CR);
  assign is_nl     = (ch_i == stl_pkg::CH_NL);

  always_comb begin
    is_op_mode = 1'b0;
    cont       = 1'b0;
    unique case (mode_q)
      stl_pkg::MODE_WORD: cont = is_word;
      stl_pkg::MODE_NUM:  cont = is_digit;
      stl_pkg::MODE_STR:  cont = 1'b1;
      stl_pkg::MODE_EQ, stl_pkg::MODE_BANG, stl_pkg::MODE_LT, stl_pkg::MODE_GT: begin
        is_op_mode = 1'b1;
        cont       = (ch_i == stl_pkg::CH_EQUALS);
      end
      default: cont = 1'b0;
    endcase
  end

  assign pending   = (mode_q != stl_pkg::MODE_IDLE) && (mode_q != stl_pkg::MODE_STR);
  assign flush_en  = pending && (end_of_input_i || !cont);
  assign start_en  = !end_of_input_i && ((mode_q == stl_pkg::MODE_IDLE) ||
                                         (pending && !cont));
  assign single_en = start_en && !(is_quote || is_op2 || is_space || is_nl ||
                                   is_wstart || is_digit);

  // Next scan state.
  always_comb begin
    mode_d      = mode_q;
    tok_start_d = tok_start_q;
    pos_d       = pos_q;
    line_d      = line_q;
    kw_buf_d    = kw_buf_q;
    too_long_d  = too_long_q;
    if (end_of_input_i) begin
      mode_d      = stl_pkg::MODE_IDLE;
      tok_start_d = '0;
      pos_d       = '0;
      line_d      = LINE_BITS'(1);
      kw_buf_d    = '0;
      too_long_d  = 1'b0;
    end else if (start_en) begin
      tok_start_d = is_quote ? pos_inc : pos_q;
      pos_d       = pos_inc;
      mode_d      = stl_pkg::MODE_IDLE;
      priority if (is_quote) begin
        mode_d = stl_pkg::MODE_STR;
      end else if (ch_i == stl_pkg::CH_EQUALS) begin
        mode_d = stl_pkg::MODE_EQ;
      end else if (ch_i == stl_pkg::CH_BANG) begin
        mode_d = stl_pkg::MODE_BANG;
      end else if (ch_i == stl_pkg::CH_LESS) begin
        mode_d = stl_pkg::MODE_LT;
      end else if (ch_i == stl_pkg::CH_GREATER) begin
        mode_d = stl_pkg::MODE_GT;
      end else if (is_nl) begin
        line_d = line_inc;
      end else if (is_wstart) begin
        mode_d     = stl_pkg::MODE_WORD;
        kw_buf_d   = {{(KW_W - 8){1'b0}}, ch_i};
        too_long_d = 1'b0;
      end else if (is_digit) begin
        mode_d = stl_pkg::MODE_NUM;
      end else begin
        // Spaces, single-byte tokens and error bytes leave the scanner idle.
        mode_d = stl_pkg::MODE_IDLE;
      end
    end else begin
      // Continuation of the pending token or string content.
      pos_d = pos_inc;
      if (mode_q == stl_pkg::MODE_WORD) begin
        too_long_d = too_long_q || (kw_buf_q[KW_W-1 -: 8] != 8'h00);
        kw_buf_d   = {kw_buf_q[KW_W-9:0], ch_i};
      end
      if ((mode_q == stl_pkg::MODE_STR && is_quote) || is_op_mode) begin
        mode_d = stl_pkg::MODE_IDLE;
      end
    end
  end

  // Tokens caused by this byte: a flushed pending token first, then the second one.
  always_comb begin
    stl_pkg::token_e flush_kind;
    stl_pkg::token_e pair_kind;
    unique case (mode_q)
      stl_pkg::MODE_WORD: flush_kind = stl_pkg::word_code(kw_buf_q, too_long_q);
      stl_pkg::MODE_NUM:  flush_kind = stl_pkg::TOK_NUMBER;
      stl_pkg::MODE_EQ:   flush_kind = stl_pkg::TOK_ASSIGN;
      stl_pkg::MODE_BANG: flush_kind = stl_pkg::TOK_ERROR;
      stl_pkg::MODE_LT:   flush_kind = stl_pkg::TOK_LESS;
      stl_pkg::MODE_GT:   flush_kind = stl_pkg::TOK_GREATER;
      default:            flush_kind = stl_pkg::TOK_ERROR;
    endcase
    unique case (mode_q)
      stl_pkg::MODE_EQ:   pair_kind = stl_pkg::TOK_EQEQ;
      stl_pkg::MODE_BANG: pair_kind = stl_pkg::TOK_NEQ;
      stl_pkg::MODE_LT:   pair_kind = stl_pkg::TOK_LESSEQ;
      default:            pair_kind = stl_pkg::TOK_GREATEREQ;
    endcase

    a_en        = flush_en;
    res_a.kind  = flush_kind;
    res_a.start = tok_start_q;
    res_a.len   = pos_q - tok_start_q;
    res_a.line  = line_q;

    b_en        = 1'b0;
    res_b.kind  = stl_pkg::TOK_EOF;
    res_b.start = pos_q;
    res_b.len   = '0;
    res_b.line  = line_q;
    res_b.last  = 1'b1;
    priority if (end_of_input_i) begin
      b_en = 1'b1;
      if (mode_q == stl_pkg::MODE_STR) begin
        res_b.kind  = stl_pkg::TOK_UNTERM;
        res_b.start = tok_start_q;
        res_b.len   = pos_q - tok_start_q;
      end
    end else if (mode_q == stl_pkg::MODE_STR) begin
      b_en        = is_quote;
      res_b.kind  = stl_pkg::TOK_STRING;
      res_b.start = tok_start_q;
      res_b.len   = pos_q - tok_start_q;
    end else if (is_op_mode && cont) begin
      b_en        = 1'b1;
      res_b.kind  = pair_kind;
      res_b.start = tok_start_q;
      res_b.len   = pos_inc - tok_start_q;
    end else if (single_en) begin
      b_en        = 1'b1;
      res_b.kind  = stl_pkg::single_code(ch_i);
      res_b.start = pos_q;
      res_b.len   = pos_inc - pos_q;
    end else begin
      b_en = 1'b0;
    end
    res_a.last = !b_en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= stl_pkg::MODE_IDLE;
      tok_start_q <= '0;
      pos_q       <= '0;
      line_q      <= LINE_BITS'(1);
      kw_buf_q    <= '0;
      too_long_q  <= 1'b0;
    end else if (in_fire) begin
      mode_q      <= mode_d;
      tok_start_q <= tok_start_d;
      pos_q       <= pos_d;
      line_q      <= line_d;
      kw_buf_q    <= kw_buf_d;
      too_long_q  <= too_long_d;
    end
  end

  // Result queue.
  logic [1:0] push_n;
  assign push_n = in_fire ? (2'(a_en) + 2'(b_en)) : 2'd0;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (a_en) begin
        mem_q[wr_ptr_q] <= res_a;
        if (b_en) begin
          mem_q[wr_ptr_q + PTR_W'(1)] <= res_b;
        end
      end else if (b_en) begin
        mem_q[wr_ptr_q] <= res_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(out_fire);
      cnt_q    <= cnt_q + CNT_W'(push_n) - CNT_W'(out_fire);
    end
  end

  assign out_valid_o  = (cnt_q != '0);
  assign token_type_o = mem_q[rd_ptr_q].kind;
  assign start_pos_o  = mem_q[rd_ptr_q].start;
  assign length_o     = mem_q[rd_ptr_q].len;
  assign line_no_o    = mem_q[rd_ptr_q].line;
  assign last_o       = mem_q[rd_ptr_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  a_eoi_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_input_i) |=>
      (mode_q == stl_pkg::MODE_IDLE && pos_q == '0 && line_q == LINE_BITS'(1)))
    else $error("end mark did not restore scan state");

  a_eoi_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_input_i) |=> out_valid_o)
    else $error("end mark produced no result");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count wrapped to zero");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (token_type_o <= 5'(stl_pkg::TOK_UNTERM)))
    else $error("token type out of range");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for source_text_lexer: predicts the token stream of every
// accepted byte and compares each delivered token field by field. Depends on stl_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned POS_W  = stl_pkg::POS_BITS_DEF;
  localparam int unsigned LINE_W = stl_pkg::LINE_BITS_DEF;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_item_t;

  typedef struct packed {
    stl_pkg::token_e   kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic              last;
  } token_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        ch_i;
  logic              end_of_input_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [4:0]        token_type_o;
  logic [POS_W-1:0]  start_pos_o;
  logic [POS_W-1:0]  length_o;
  logic [LINE_W-1:0] line_no_o;
  logic              last_o;

  src_item_t pending_bytes [$];
  src_item_t next_item;
  token_t    tokens_due [$];
  int        mismatch_count = 0;
  int        item_tokens;
  bit        req_taken = 1'b0;
  bit        res_taken = 1'b0;
  bit        in_calm = 1'b0;
  bit        out_calm = 1'b0;
  int        in_gap = 0;
  int        out_stall = 0;

  string kw_words [8] = '{"if", "else", "while", "int", "bool", "true", "false", "print"};
  string op_list [17] = '{"(", ")", "{", "}", ";", "+", "-", "*", "/",
                          "=", "==", "!=", "<", "<=", ">", ">=", "!"};

  // Scanner state of the predictor.
  stl_pkg::scan_mode_e lex_mode;
  logic [POS_W-1:0]    tok_start;
  logic [POS_W-1:0]    pos;
  logic [LINE_W-1:0]   line_cnt;
  logic [39:0]         kw_buf;
  logic                word_long;

  source_text_lexer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_type_o   (token_type_o),
    .start_pos_o    (start_pos_o),
    .length_o       (length_o),
    .line_no_o      (line_no_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("source_text_lexer verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [39:0] pack_text(input string s);
    logic [39:0] v;
    v = '0;
    for (int i = 0; i < s.len(); i++) v = {v[31:0], s[i]};
    return v;
  endfunction

  function automatic void clear_scan();
    lex_mode  = stl_pkg::MODE_IDLE;
    tok_start = '0;
    pos       = '0;
    line_cnt  = LINE_W'(1);
    kw_buf    = '0;
    word_long = 1'b0;
  endfunction

  function automatic void advance_pos();
    if (pos != {POS_W{1'b1}}) pos = pos + POS_W'(1);
  endfunction

  function automatic void note_token(input stl_pkg::token_e kind,
                                     input logic [POS_W-1:0] start,
                                     input logic [POS_W-1:0] len);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line_cnt;
    t.last  = 1'b0;
    tokens_due.push_back(t);
    item_tokens++;
  endfunction

  // Words longer than five bytes have lost their head from the buffer, so they are
  // never keywords.
  function automatic stl_pkg::token_e word_kind();
    stl_pkg::token_e kind;
    kind = stl_pkg::TOK_IDENT;
    if (!word_long) begin
      for (int k = 0; k < 8; k++) begin
        if (kw_buf == pack_text(kw_words[k])) kind = stl_pkg::token_e'(stl_pkg::TOK_IF + k);
      end
    end
    return kind;
  endfunction

  function automatic void flush_pending();
    logic [POS_W-1:0] len;
    len = pos - tok_start;
    case (lex_mode)
      stl_pkg::MODE_WORD: note_token(word_kind(), tok_start, len);
      stl_pkg::MODE_NUM:  note_token(stl_pkg::TOK_NUMBER, tok_start, len);
      stl_pkg::MODE_EQ:   note_token(stl_pkg::TOK_ASSIGN, tok_start, len);
      stl_pkg::MODE_BANG: note_token(stl_pkg::TOK_ERROR, tok_start, len);
      stl_pkg::MODE_LT:   note_token(stl_pkg::TOK_LESS, tok_start, len);
      stl_pkg::MODE_GT:   note_token(stl_pkg::TOK_GREATER, tok_start, len);
      default: ;
    endcase
    lex_mode = stl_pkg::MODE_IDLE;
  endfunction

  function automatic void begin_token(input logic [7:0] c);
    stl_pkg::token_e kind;
    bit              one_byte;
    tok_start = pos;
    advance_pos();
    one_byte = 1'b0;
    kind     = stl_pkg::TOK_ERROR;
    case (c)
      stl_pkg::CH_QUOTE: begin
        tok_start = pos;
        lex_mode  = stl_pkg::MODE_STR;
      end
      stl_pkg::CH_LPAREN: begin kind = stl_pkg::TOK_LPAREN; one_byte = 1'b1; end
      stl_pkg::CH_RPAREN: begin kind = stl_pkg::TOK_RPAREN; one_byte = 1'b1; end
      stl_pkg::CH_LBRACE: begin kind = stl_pkg::TOK_LBRACE; one_byte = 1'b1; end
      stl_pkg::CH_RBRACE: begin kind = stl_pkg::TOK_RBRACE; one_byte = 1'b1; end
      stl_pkg::CH_SEMI:   begin kind = stl_pkg::TOK_SEMI;   one_byte = 1'b1; end
      stl_pkg::CH_PLUS:   begin kind = stl_pkg::TOK_PLUS;   one_byte = 1'b1; end
      stl_pkg::CH_MINUS:  begin kind = stl_pkg::TOK_MINUS;  one_byte = 1'b1; end
      stl_pkg::CH_STAR:   begin kind = stl_pkg::TOK_STAR;   one_byte = 1'b1; end
      stl_pkg::CH_SLASH:  begin kind = stl_pkg::TOK_SLASH;  one_byte = 1'b1; end
      stl_pkg::CH_EQUALS:  lex_mode = stl_pkg::MODE_EQ;
      stl_pkg::CH_BANG:    lex_mode = stl_pkg::MODE_BANG;
      stl_pkg::CH_LESS:    lex_mode = stl_pkg::MODE_LT;
      stl_pkg::CH_GREATER: lex_mode = stl_pkg::MODE_GT;
      stl_pkg::CH_SPACE, stl_pkg::CH_CR, stl_pkg::CH_TAB: ;
      stl_pkg::CH_NL: begin
        if (line_cnt != {LINE_W{1'b1}}) line_cnt = line_cnt + LINE_W'(1);
      end
      default: begin
        if (is_alpha(c) || c == stl_pkg::CH_UNDER) begin
          kw_buf    = {32'b0, c};
          word_long = 1'b0;
          lex_mode  = stl_pkg::MODE_WORD;
        end else if (is_digit(c)) begin
          lex_mode = stl_pkg::MODE_NUM;
        end else begin
          one_byte = 1'b1;
        end
      end
    endcase
    if (one_byte) note_token(kind, tok_start, pos - tok_start);
  endfunction

  function automatic void scan_byte(input logic [7:0] c, input logic eoi);
    token_t          t;
    stl_pkg::token_e kind;
    item_tokens = 0;
    if (eoi) begin
      if (lex_mode == stl_pkg::MODE_STR) begin
        note_token(stl_pkg::TOK_UNTERM, tok_start, pos - tok_start);
      end else begin
        flush_pending();
        note_token(stl_pkg::TOK_EOF, pos, '0);
      end
      clear_scan();
    end else begin
      case (lex_mode)
        stl_pkg::MODE_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == stl_pkg::CH_UNDER) begin
            if (kw_buf[39:32] != 8'h00) word_long = 1'b1;
            kw_buf = {kw_buf[31:0], c};
            advance_pos();
          end else begin
            flush_pending();
            begin_token(c);
          end
        end
        stl_pkg::MODE_NUM: begin
          if (is_digit(c)) begin
            advance_pos();
          end else begin
            flush_pending();
            begin_token(c);
          end
        end
        stl_pkg::MODE_STR: begin
          if (c == stl_pkg::CH_QUOTE) begin
            note_token(stl_pkg::TOK_STRING, tok_start, pos - tok_start);
            advance_pos();
            lex_mode = stl_pkg::MODE_IDLE;
          end else begin
            advance_pos();
          end
        end
        stl_pkg::MODE_EQ, stl_pkg::MODE_BANG, stl_pkg::MODE_LT, stl_pkg::MODE_GT: begin
          if (c == stl_pkg::CH_EQUALS) begin
            case (lex_mode)
              stl_pkg::MODE_EQ:   kind = stl_pkg::TOK_EQEQ;
              stl_pkg::MODE_BANG: kind = stl_pkg::TOK_NEQ;
              stl_pkg::MODE_LT:   kind = stl_pkg::TOK_LESSEQ;
              default:            kind = stl_pkg::TOK_GREATEREQ;
            endcase
            advance_pos();
            note_token(kind, tok_start, pos - tok_start);
            lex_mode = stl_pkg::MODE_IDLE;
          end else begin
            flush_pending();
            begin_token(c);
          end
        end
        default: begin
          lex_mode = stl_pkg::MODE_IDLE;
          begin_token(c);
        end
      endcase
    end
    if (item_tokens > 0) begin
      t = tokens_due.pop_back();
      t.last = 1'b1;
      tokens_due.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("token type %0d delivered with none outstanding",
                                token_type_o));
    end else begin
      want = tokens_due.pop_front();
      if (token_type_o !== want.kind)
        report_mismatch($sformatf("type %0d, expected %0d", token_type_o, want.kind));
      if (start_pos_o !== want.start)
        report_mismatch($sformatf("start %0d, expected %0d", start_pos_o, want.start));
      if (length_o !== want.len)
        report_mismatch($sformatf("length %0d, expected %0d", length_o, want.len));
      if (line_no_o !== want.line)
        report_mismatch($sformatf("line %0d, expected %0d", line_no_o, want.line));
      if (last_o !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last_o, want.last));
    end
  endtask

  // Requests are predicted before results are checked, so a token is always
  // expected before it can turn up.
  always @(posedge clk_i) begin
    req_taken = 1'b0;
    res_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        req_taken = 1'b1;
        scan_byte(ch_i, end_of_input_i);
      end
      if (out_valid_o && out_ready_i) begin
        res_taken = 1'b1;
        check_token();
      end
    end
  end

  // ---------------------------------------------------------------- driving

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (req_taken) begin
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, 11);
        end
        if (in_gap > 0 || pending_bytes.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid_i <= 1'b0;
        end else begin
          next_item = pending_bytes.pop_front();
          ch_i           <= next_item.ch;
          end_of_input_i <= next_item.eoi;
          in_valid_i     <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 11);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void push_byte(input logic [7:0] c);
    src_item_t it;
    it.ch  = c;
    it.eoi = 1'b0;
    pending_bytes.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // The byte carried with an end mark is meant to be ignored, so it is random.
  function automatic void push_end();
    src_item_t it;
    it.ch  = 8'($urandom_range(0, 255));
    it.eoi = 1'b1;
    pending_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] rand_word_char(input bit lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return stl_pkg::CH_UNDER;
    return 8'(8'h30 + r - 53);
  endfunction

  initial begin
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    ch_i           = 8'h00;
    end_of_input_i = 1'b0;
    out_ready_i    = 1'b0;
    clear_scan();

    // Keyword, punctuation, a comparison pair and a string still open at the end
    // mark, with a newline inside it.
    push_text("while(_a<=9)\"q\n");
    push_end();
    // A bang followed by a word, an equality, NUL and a top-bit byte, then a
    // pending operator flushed by the end mark.
    push_text("!x==y");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(stl_pkg::CH_GREATER);
    push_end();

    // Mostly well-formed token sequences with random content, plus raw noise.
    while (pending_bytes.size() < 548) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        push_text(kw_words[$urandom_range(0, 7)]);
        if ($urandom_range(0, 4) == 0) push_byte(rand_word_char(1'b0));
      end else if (pick < 27) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        push_byte(rand_word_char(1'b1));
        for (int i = 1; i < n; i++) push_byte(rand_word_char(1'b0));
      end else if (pick < 37) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_byte(8'(8'h30 + $urandom_range(0, 9)));
      end else if (pick < 47) begin
        push_byte(stl_pkg::CH_QUOTE);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          c = ($urandom_range(0, 4) == 0) ? stl_pkg::CH_NL : 8'($urandom_range(0, 255));
          if (c == stl_pkg::CH_QUOTE) c = stl_pkg::CH_SPACE;
          push_byte(c);
        end
        if ($urandom_range(0, 9) == 0) push_end();
        else push_byte(stl_pkg::CH_QUOTE);
      end else if (pick < 72) begin
        push_text(op_list[$urandom_range(0, 16)]);
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: push_byte(stl_pkg::CH_SPACE);
          1: push_byte(stl_pkg::CH_TAB);
          2: push_byte(stl_pkg::CH_CR);
          default: push_byte(stl_pkg::CH_NL);
        endcase
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 29) == 0) push_end();
    end
    push_end();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    while (tokens_due.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("source_text_lexer verification clean");
    end else begin
      $display("source_text_lexer verification failed");
    end
    $finish;
  end

endmodule
